FILE: rtl/pmd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the block.
package pmd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MOVE_W  = 9;
  localparam int unsigned WHEEL_W = 5;
  localparam int unsigned BTN_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_BUTTON = 2'd1;

  // First-byte flag bits
  localparam int unsigned B0_SYNC_BIT = 3;
  localparam int unsigned B0_XSGN_BIT = 4;
  localparam int unsigned B0_YSGN_BIT = 5;
  localparam int unsigned B0_XOVF_BIT = 6;
  localparam int unsigned B0_YOVF_BIT = 7;

  // Fourth-byte fields
  localparam logic [3:0] WHEEL_NIB_NEG1 = 4'hF;
  localparam logic [1:0] WHEEL_TAG_HORZ = 2'b01;
  localparam int unsigned B3_BACK_BIT = 4;
  localparam int unsigned B3_FWD_BIT  = 5;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } pos_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } pkt_t;

  typedef struct packed {
    logic wheel_mode;
    logic five_button_mode;
  } cfg_t;

endpackage

FILE: rtl/pmd_assembler.sv
// Byte sequencer: syncs on the first byte and gathers a packet.
// Depends on pmd_pkg.
module pmd_assembler
  import pmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_take,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              wheel_mode,
  output pkt_t              pkt
);

  pos_t              pos_r, pos_nxt;
  logic [BYTE_W-1:0] b0_r, b1_r, b2_r;

  // Next position
  always_comb begin
    pos_nxt = pos_r;
    if (byte_take) begin
      case (pos_r)
        POS_FIRST:  pos_nxt = byte_in[B0_SYNC_BIT] ? POS_SECOND : POS_FIRST;
        POS_SECOND: pos_nxt = POS_THIRD;
        POS_THIRD:  pos_nxt = wheel_mode ? POS_FOURTH : POS_FIRST;
        POS_FOURTH: pos_nxt = POS_FIRST;
        default:    pos_nxt = POS_FIRST;
      endcase
    end
  end

  // Packet outputs
  always_comb begin
    pkt.done = 1'b0;
    pkt.b0   = b0_r;
    pkt.b1   = b1_r;
    pkt.b2   = b2_r;
    pkt.b3   = byte_in;
    case (pos_r)
      POS_THIRD: begin
        pkt.done = byte_take && !wheel_mode;
        pkt.b2   = byte_in;
        pkt.b3   = '0;
      end
      POS_FOURTH: pkt.done = byte_take;
      default:    pkt.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      case (pos_r)
        POS_FIRST:  b0_r <= byte_in;
        POS_SECOND: b1_r <= byte_in;
        POS_THIRD:  b2_r <= byte_in;
        default:    b0_r <= b0_r;
      endcase
    end
  end

endmodule

FILE: rtl/pmd_decode.sv
// Packet field decode: movement, wheel and buttons from a complete packet.
// Depends on pmd_pkg.
module pmd_decode
  import pmd_pkg::*;
(
  input  pkt_t               pkt,
  input  cfg_t               cfg,
  output logic [MOVE_W-1:0]  move_x,
  output logic [MOVE_W-1:0]  move_y,
  output logic [WHEEL_W-1:0] wheel_v,
  output logic [WHEEL_W-1:0] wheel_h,
  output logic [BTN_W-1:0]   buttons
);

  logic               ovf;
  logic [3:0]         nib;
  logic [WHEEL_W-1:0] zv;
  logic               horz;

  always_comb begin
    ovf = pkt.b0[B0_XOVF_BIT] | pkt.b0[B0_YOVF_BIT];
    // A zero magnitude stays zero whatever the sign bit says
    move_x = {pkt.b0[B0_XSGN_BIT] & (pkt.b1 != '0), pkt.b1};
    move_y = {pkt.b0[B0_YSGN_BIT] & (pkt.b2 != '0), pkt.b2};
    if (ovf) begin
      move_x = '0;
      move_y = '0;
    end

    nib  = pkt.b3[3:0];
    zv   = (nib == WHEEL_NIB_NEG1) ? '1 : {1'b0, nib};
    horz = (pkt.b3[7:6] == WHEEL_TAG_HORZ);
    wheel_v = '0;
    wheel_h = '0;
    buttons = {2'b00, pkt.b0[2:0]};
    if (cfg.wheel_mode) begin
      if (horz) begin
        wheel_h = -zv;
      end else begin
        wheel_v = zv;
      end
      if (cfg.five_button_mode) begin
        buttons[3] = pkt.b3[B3_BACK_BIT];
        buttons[4] = pkt.b3[B3_FWD_BIT];
      end
    end
  end

endmodule

FILE: rtl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder, top level: configuration, sequencer, decode
// and the result register. Depends on pmd_pkg, pmd_assembler, pmd_decode.
//
// Takes one mouse byte per request and produces one decoded result per
// packet: three bytes normally, four when wheel_mode is set. Bytes are
// accepted at one per clock; a byte that completes a packet is decoded in
// the same cycle and the result appears on the out_ channel the next cycle
// from a single result register. The input stalls only while that register
// holds a result the consumer is stalling. The decoder waits for a first
// byte with bit 3 set and drops any other first byte. wheel_mode is sampled
// on the third byte to decide whether a fourth follows; the decode itself
// uses the register values current on the completing byte. X and Y are
// sign-extended to 9 bits and both zeroed if either overflow flag is set.
// The wheel nibble gives -1..14 on wheel_vertical, or its negation on
// wheel_horizontal when bits 7:6 of the fourth byte are 01. Back and
// forward buttons come from the fourth byte in five-button mode, which
// only takes effect with wheel_mode set. Configuration writes are always
// ready; indexes beyond five_button_mode are ignored. No clearing pass.
module ps2_mouse_packet_decoder
  import pmd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic                      cfg_data,
  // byte requests
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         in_data_byte,
  // results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [MOVE_W-1:0]  out_move_x,
  output logic signed [MOVE_W-1:0]  out_move_y,
  output logic signed [WHEEL_W-1:0] out_wheel_vertical,
  output logic signed [WHEEL_W-1:0] out_wheel_horizontal,
  output logic [BTN_W-1:0]          out_buttons
);

  cfg_t               cfg_r;
  logic               byte_take;
  pkt_t               pkt;
  logic [MOVE_W-1:0]  dx, dy;
  logic [WHEEL_W-1:0] dv, dh;
  logic [BTN_W-1:0]   db;

  logic               out_valid_r, out_valid_nxt;
  logic [MOVE_W-1:0]  mx_r, my_r;
  logic [WHEEL_W-1:0] wv_r, wh_r;
  logic [BTN_W-1:0]   btn_r;

  assign cfg_ready = 1'b1;

  // Hold the config registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WHEEL_MODE:  cfg_r.wheel_mode       <= cfg_data;
        CFG_FIVE_BUTTON: cfg_r.five_button_mode <= cfg_data;
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // Stall the input only while a finished result is held up downstream
  assign in_stall  = out_valid_r && out_stall;
  assign byte_take = in_valid && !in_stall;

  pmd_assembler u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_take  (byte_take),
    .byte_in    (in_data_byte),
    .wheel_mode (cfg_r.wheel_mode),
    .pkt        (pkt)
  );

  pmd_decode u_dec (
    .pkt     (pkt),
    .cfg     (cfg_r),
    .move_x  (dx),
    .move_y  (dy),
    .wheel_v (dv),
    .wheel_h (dh),
    .buttons (db)
  );

  // Result register: load on completion, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pkt.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.done) begin
      mx_r  <= dx;
      my_r  <= dy;
      wv_r  <= dv;
      wh_r  <= dh;
      btn_r <= db;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_move_x           = mx_r;
  assign out_move_y           = my_r;
  assign out_wheel_vertical   = wv_r;
  assign out_wheel_horizontal = wh_r;
  assign out_buttons          = btn_r;

endmodule
